// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent, checked on every clock edge outside reset.
`define DVF_ASSERT_IMPLY(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true outside reset.
`define DVF_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ----- hw/rtl/dvf_pkg.sv -----
package dvf_pkg;

   localparam int TABLE_DEPTH_DEF = 16384;
   localparam int WAYS_DEF        = 4;
   localparam int VERTEX_BITS_DEF = 32;
   localparam int OUT_BITS        = 32;

   typedef enum logic [1:0] {
      MODE_VERTEX     = 2'd0,
      MODE_LEVEL_END  = 2'd1,
      MODE_NEW_SEARCH = 2'd2
   } mode_type;

   typedef struct packed {
      logic load_req;
      logic wr_insert;
      logic wr_clear;
      logic out_vertex;
      logic out_done;
      logic ptr_rst;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic clr_last;
      logic out_free;
   } sts_type;

endpackage

// ----- hw/rtl/dvf_ram.sv -----
module dvf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/dvf_ctrl.sv -----
module dvf_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic [1:0]      req_mode,
   output logic            req_ready,
   input  dvf_pkg::sts_type sts,
   output dvf_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_READ  = 4'b0100,
      ST_CMP   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE) && sts.out_free;
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.wr_clear = 1'b1;
            if (sts.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load_req = 1'b1;
               case (dvf_pkg::mode_type'(req_mode))
                  dvf_pkg::MODE_VERTEX: begin
                     state_in = ST_READ;
                  end
                  dvf_pkg::MODE_LEVEL_END: begin
                     cmd.out_done = 1'b1;
                     cmd.ptr_rst  = 1'b1;
                  end
                  dvf_pkg::MODE_NEW_SEARCH: begin
                     cmd.ptr_rst = 1'b1;
                     state_in    = ST_CLEAR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!sts.hit) begin
               cmd.wr_insert  = 1'b1;
               cmd.out_vertex = 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- hw/rtl/dvf_datapath.sv -----
module dvf_datapath #(
   parameter int TABLE_DEPTH = dvf_pkg::TABLE_DEPTH_DEF,
   parameter int WAYS        = dvf_pkg::WAYS_DEF,
   parameter int VERTEX_BITS = dvf_pkg::VERTEX_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [VERTEX_BITS-1:0]        req_vertex,
   input  dvf_pkg::cmd_type              cmd,
   output dvf_pkg::sts_type              sts,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dvf_pkg::OUT_BITS-1:0]  rsp_vertex_out,
   output logic                          rsp_level_done
);

   localparam int ROW_BITS = $clog2(TABLE_DEPTH);
   localparam int TAG_BITS = VERTEX_BITS - ROW_BITS;
   localparam int PTR_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W    = WAYS * TAG_BITS;
   localparam int OUT_BITS = dvf_pkg::OUT_BITS;

   logic [ROW_BITS-1:0] row_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [PTR_BITS-1:0] ptr_ff;
   logic [PTR_BITS-1:0] ptr_in;
   logic [ROW_BITS-1:0] clr_cnt_ff;
   logic [ROW_BITS-1:0] clr_cnt_in;
   logic [ROW_W-1:0]    rd_row;
   logic [ROW_W-1:0]    ins_row;
   logic [ROW_W-1:0]    wr_data;
   logic [ROW_BITS-1:0] wr_addr;
   logic                hit;

   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [OUT_BITS-1:0]          rsp_vertex_out_ff;
   logic                         rsp_level_done_ff;
   logic [VERTEX_BITS+OUT_BITS-1:0] vertex_ext;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         row_ff <= req_vertex[ROW_BITS-1:0];
         tag_ff <= req_vertex[VERTEX_BITS-1:ROW_BITS];
      end
   end

   always_comb begin
      hit     = 1'b0;
      ins_row = rd_row;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row[w*TAG_BITS +: TAG_BITS] == tag_ff) begin
            hit = 1'b1;
         end
         if (ptr_ff == PTR_BITS'(w)) begin
            ins_row[w*TAG_BITS +: TAG_BITS] = tag_ff;
         end
      end
   end

   assign wr_addr = cmd.wr_clear ? clr_cnt_ff : row_ff;
   assign wr_data = cmd.wr_clear ? {ROW_W{1'b1}} : ins_row;

   dvf_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_DEPTH)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (cmd.wr_insert || cmd.wr_clear),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (row_ff),
      .rd_data (rd_row)
   );

   always_comb begin
      ptr_in = ptr_ff;
      if (cmd.ptr_rst) begin
         ptr_in = '0;
      end else if (cmd.wr_insert) begin
         ptr_in = (ptr_ff == PTR_BITS'(WAYS - 1)) ? '0 : ptr_ff + 1'b1;
      end
   end

   assign clr_cnt_in = cmd.wr_clear ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff     <= '0;
         clr_cnt_ff <= '0;
      end else begin
         ptr_ff     <= ptr_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   assign vertex_ext = {{OUT_BITS{1'b0}}, tag_ff, row_ff};

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_vertex || cmd.out_done) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_vertex) begin
         rsp_vertex_out_ff <= vertex_ext[OUT_BITS-1:0];
         rsp_level_done_ff <= 1'b0;
      end else if (cmd.out_done) begin
         rsp_vertex_out_ff <= '0;
         rsp_level_done_ff <= 1'b1;
      end
   end

   assign sts.hit      = hit;
   assign sts.clr_last = (clr_cnt_ff == ROW_BITS'(TABLE_DEPTH - 1));
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vertex_out = rsp_vertex_out_ff;
   assign rsp_level_done = rsp_level_done_ff;

endmodule

// ----- hw/rtl/duplicate_vertex_filter.sv -----
// Duplicate vertex filter: passes on a vertex index only if its tag is not yet held in its row.
// Input channel req_: req_mode selects a vertex item, an end of level or a new
// search; req_vertex carries the index. Result channel rsp_: rsp_vertex_out
// with rsp_level_done low for a passed vertex, or zero with rsp_level_done high
// for the end-of-level marker. Repeated vertices and new-search items give no
// result.
// A vertex item passes from acceptance to its result through accept, tag row
// read, and compare and write back; the block takes no new item until the
// compare is done, as the single tag memory is read through a register.
// An end-of-level item shows its marker in the following cycle.
// A new-search item sweeps the tag memory, one row per cycle, and the block
// accepts no item until all TABLE_DEPTH rows (16384 at default size) are cleared.
// After reset the same sweep runs, so req_ready stays low until it ends. While
// the receiver stalls, the result is held in the output register and req_ready
// stays low until that register is free or being emptied in the same cycle.
module duplicate_vertex_filter #(
   parameter int TABLE_DEPTH = dvf_pkg::TABLE_DEPTH_DEF,
   parameter int WAYS        = dvf_pkg::WAYS_DEF,
   parameter int VERTEX_BITS = dvf_pkg::VERTEX_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_mode,
   input  logic [VERTEX_BITS-1:0]       req_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [dvf_pkg::OUT_BITS-1:0] rsp_vertex_out,
   output logic                         rsp_level_done
);

   dvf_pkg::cmd_type cmd;
   dvf_pkg::sts_type sts;

   dvf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   dvf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .WAYS        (WAYS),
      .VERTEX_BITS (VERTEX_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_vertex     (req_vertex),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_vertex_out (rsp_vertex_out),
      .rsp_level_done (rsp_level_done)
   );

endmodule

// ----- hw/rtl/dvf_checker.sv -----
`include "assert_macros.svh"

module dvf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [1:0]                   req_mode,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [dvf_pkg::OUT_BITS-1:0] rsp_vertex_out,
   input logic                         rsp_level_done
);

   logic take_vertex;
   logic take_level;
   logic marker_shown;

   assign take_vertex  = req_valid && req_ready && (req_mode == dvf_pkg::MODE_VERTEX);
   assign take_level   = req_valid && req_ready && (req_mode == dvf_pkg::MODE_LEVEL_END);
   assign marker_shown = rsp_valid && rsp_level_done;

   // A result that is not taken stays offered.
   `DVF_ASSERT_IMPLY(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "result dropped")

   // The end-of-level marker always carries a zero vertex.
   `DVF_ASSERT_NEVER(a_done_zero, marker_shown && (rsp_vertex_out != '0), "marker not zero")

   // A vertex item is looked up in the read and compare states, so no item follows at once.
   `DVF_ASSERT_IMPLY(a_vertex_busy, take_vertex |=> !req_ready, "item taken during lookup")

   // An end-of-level item shows its marker in the next cycle.
   `DVF_ASSERT_IMPLY(a_level_marker, take_level |=> marker_shown, "marker missing")

endmodule

bind duplicate_vertex_filter dvf_checker u_dvf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_mode       (req_mode),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_vertex_out (rsp_vertex_out),
   .rsp_level_done (rsp_level_done)
);

// ----- bench/tb_duplicate_vertex_filter.sv -----
module tb_duplicate_vertex_filter;

   localparam int VB        = dvf_pkg::VERTEX_BITS_DEF;
   localparam int DEPTH     = dvf_pkg::TABLE_DEPTH_DEF;
   localparam int WAYS      = dvf_pkg::WAYS_DEF;
   localparam int OB        = dvf_pkg::OUT_BITS;
   localparam int ROW_BITS  = $clog2(DEPTH);
   localparam int TAG_BITS  = VB - ROW_BITS;
   localparam int RANDOM_ITEMS  = 500;
   localparam int MAX_SEARCHES  = 8;
   localparam int STALL_LIMIT   = 50000;
   localparam int DRAIN_CYCLES  = 16;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam logic [TAG_BITS-1:0] TAG_CLEARED = '1;

   typedef struct packed {
      logic [1:0]    mode;
      logic [VB-1:0] vertex;
   } vertex_item_type;

   typedef struct packed {
      logic [OB-1:0] vertex_out;
      logic          level_done;
   } filter_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_mode = dvf_pkg::MODE_VERTEX;
   logic [VB-1:0]       req_vertex = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [OB-1:0]       rsp_vertex_out;
   logic                rsp_level_done;

   vertex_item_type   stream_q[$];
   filter_result_type forwarded_q[$];
   logic [TAG_BITS-1:0] tag_mem [WAYS][DEPTH];
   int victim_ptr;

   int cycle_count;
   int items_total;
   int items_accepted;
   int results_checked;
   int mismatches;
   int dropped_count;
   int n_vertex, n_level, n_search, n_unused;
   int idle_cycles;

   duplicate_vertex_filter i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_mode       (req_mode),
      .req_vertex     (req_vertex),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_vertex_out (rsp_vertex_out),
      .rsp_level_done (rsp_level_done)
   );

   always #2 clock = ~clock;

   task automatic log_mismatch(input string what);
      $display("MISMATCH (cycle %0d): %s", cycle_count, what);
      mismatches++;
   endtask

   task automatic clear_tag_mem();
      int w;
      int r;
      for (w = 0; w < WAYS; w++)
         for (r = 0; r < DEPTH; r++)
            tag_mem[w][r] = TAG_CLEARED;
   endtask

   task automatic filter_step(input logic [1:0] mode, input logic [VB-1:0] vertex);
      logic [ROW_BITS-1:0] row;
      logic [TAG_BITS-1:0] tag;
      logic                hit;
      filter_result_type   res;
      int w;
      row = vertex[ROW_BITS-1:0];
      tag = vertex[VB-1:ROW_BITS];
      hit = 1'b0;
      case (mode)
         dvf_pkg::MODE_VERTEX: begin
            for (w = 0; w < WAYS; w++)
               if (tag_mem[w][row] == tag)
                  hit = 1'b1;
            if (hit) begin
               dropped_count++;
            end else begin
               tag_mem[victim_ptr][row] = tag;
               victim_ptr = (victim_ptr + 1) % WAYS;
               res.vertex_out = vertex;
               res.level_done = 1'b0;
               forwarded_q.push_back(res);
            end
         end
         dvf_pkg::MODE_LEVEL_END: begin
            victim_ptr = 0;
            res.vertex_out = '0;
            res.level_done = 1'b1;
            forwarded_q.push_back(res);
         end
         dvf_pkg::MODE_NEW_SEARCH: begin
            clear_tag_mem();
            victim_ptr = 0;
         end
         default: ;
      endcase
   endtask

   function automatic void push_item(input logic [1:0] mode, input logic [VB-1:0] vertex);
      vertex_item_type it;
      it.mode = mode;
      it.vertex = vertex;
      stream_q.push_back(it);
      case (mode)
         dvf_pkg::MODE_VERTEX:     n_vertex++;
         dvf_pkg::MODE_LEVEL_END:  n_level++;
         dvf_pkg::MODE_NEW_SEARCH: n_search++;
         default:                  n_unused++;
      endcase
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin : driver
      vertex_item_type nxt;
      logic idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            filter_step(req_mode, req_vertex);
            items_accepted++;
         end
         if (!req_valid || req_ready) begin
            idle = !(items_accepted >= 150 && items_accepted < 280)
                   && ($urandom_range(99) < 23);
            if (stream_q.size() != 0 && !idle) begin
               nxt = stream_q.pop_front();
               req_valid  <= 1'b1;
               req_mode   <= nxt.mode;
               req_vertex <= nxt.vertex;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      filter_result_type exp_res;
      logic stall;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (forwarded_q.size() == 0) begin
            log_mismatch($sformatf("unexpected result vertex_out=%h level_done=%b",
                                   rsp_vertex_out, rsp_level_done));
         end else begin
            exp_res = forwarded_q.pop_front();
            if (rsp_vertex_out !== exp_res.vertex_out)
               log_mismatch($sformatf("vertex_out %h, expected %h",
                                      rsp_vertex_out, exp_res.vertex_out));
            if (rsp_level_done !== exp_res.level_done)
               log_mismatch($sformatf("level_done %b, expected %b",
                                      rsp_level_done, exp_res.level_done));
         end
      end
      stall = !(results_checked >= 120 && results_checked < 240)
              && ($urandom_range(99) < 23);
      rsp_ready <= !reset && !stall;
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [ROW_BITS-1:0] hot_row [4];
      logic [TAG_BITS-1:0] hot_tag [8];
      logic [VB-1:0]       recent [$];
      logic [VB-1:0]       v;
      int counted;
      int searches;
      int pick;
      int sel;
      int k;

      cycle_count = 0;
      idle_cycles = 0;
      victim_ptr = 0;
      clear_tag_mem();

      push_item(dvf_pkg::MODE_VERTEX, 32'h0000_0000);
      push_item(dvf_pkg::MODE_VERTEX, 32'h0000_0000);
      push_item(dvf_pkg::MODE_VERTEX, 32'hFFFF_FFFF);
      push_item(dvf_pkg::MODE_VERTEX, 32'hFFFC_0000);
      for (k = 1; k <= 5; k++)
         push_item(dvf_pkg::MODE_VERTEX, {TAG_BITS'(k), ROW_BITS'(5)});
      push_item(dvf_pkg::MODE_VERTEX, {TAG_BITS'(1), ROW_BITS'(5)});
      push_item(dvf_pkg::MODE_VERTEX, {TAG_BITS'(5), ROW_BITS'(5)});
      push_item(dvf_pkg::MODE_LEVEL_END, 32'hFFFF_FFFF);
      push_item(dvf_pkg::MODE_VERTEX, {TAG_BITS'(9), ROW_BITS'(5)});
      push_item(MODE_UNUSED, 32'h1234_5678);
      push_item(dvf_pkg::MODE_VERTEX, 32'h1234_5678);
      push_item(dvf_pkg::MODE_NEW_SEARCH, 32'h0000_0000);
      push_item(dvf_pkg::MODE_VERTEX, 32'h0000_0000);
      push_item(dvf_pkg::MODE_VERTEX, 32'hAAAA_5555);
      push_item(dvf_pkg::MODE_VERTEX, 32'h5555_AAAA);
      push_item(dvf_pkg::MODE_VERTEX, 32'h0003_FFFF);
      push_item(dvf_pkg::MODE_LEVEL_END, 32'h0000_0000);

      // Most vertices come from a few rows and tags, so that hits, misses and
      // evictions all happen often.
      for (k = 0; k < 4; k++) hot_row[k] = ROW_BITS'($urandom_range(DEPTH - 1));
      for (k = 0; k < 8; k++) hot_tag[k] = TAG_BITS'($urandom);
      counted = 0;
      searches = 0;
      while (counted < RANDOM_ITEMS) begin
         pick = $urandom_range(999);
         if (pick < 10 && searches < MAX_SEARCHES) begin
            push_item(dvf_pkg::MODE_NEW_SEARCH, $urandom);
            searches++;
            counted++;
            for (k = 0; k < 4; k++) hot_row[k] = ROW_BITS'($urandom_range(DEPTH - 1));
            for (k = 0; k < 8; k++) hot_tag[k] = TAG_BITS'($urandom);
         end else if (pick < 60) begin
            push_item(dvf_pkg::MODE_LEVEL_END, $urandom);
            counted++;
         end else if (pick < 80) begin
            push_item(MODE_UNUSED, $urandom);
         end else begin
            sel = $urandom_range(99);
            if (sel < 60)
               v = {hot_tag[$urandom_range(7)], hot_row[$urandom_range(3)]};
            else if (sel < 75 && recent.size() != 0)
               v = recent[$urandom_range(recent.size() - 1)];
            else if (sel < 80)
               v = {TAG_CLEARED, ROW_BITS'($urandom)};
            else
               v = $urandom;
            push_item(dvf_pkg::MODE_VERTEX, v);
            recent.push_back(v);
            if (recent.size() > 16) recent.pop_front();
            counted++;
         end
      end
      items_total = stream_q.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (items_accepted != items_total) @(posedge clock);
      while (forwarded_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Stimulus: %0d vertices, %0d level ends, %0d new searches, %0d unused codes",
               n_vertex, n_level, n_search, n_unused);
      $display("Checked %0d results; %0d vertices dropped as repeats; %0d mismatches",
               results_checked, dropped_count, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
